// ----- rtl/tse_pkg.sv -----
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types and constants for the TLS server-name extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package tse_pkg;

	localparam int NAME_MAX_DEF  = 256;
	localparam int NAME_LEN_W    = 16;
	localparam logic [7:0] EXT_LIMIT_RST = 8'd20;

	typedef enum logic [2:0] {
		ST_FOUND     = 3'd0,
		ST_NOT_TCP   = 3'd1,
		ST_NOT_HS    = 3'd2,
		ST_BAD_VER   = 3'd3,
		ST_NOT_HELLO = 3'd4,
		ST_NO_SNI    = 3'd5,
		ST_SHORT     = 3'd6
	} status_t;

	typedef enum logic {
		KIND_NAME    = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [7:0]             name_byte;
		logic [NAME_LEN_W-1:0]  name_len;
		status_t                status;
		logic                   name_truncated;
		logic                   last_name_byte;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/tse_if.sv -----
// ----------------------------------------------------------------------------
// tse interfaces
// Valid/ready channels for frame bytes, results and the configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface tse_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source (output valid, output data_byte, output frame_end, input ready);
	modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface tse_result_if;
	logic                            valid;
	logic                            ready;
	tse_pkg::kind_t                  kind;
	logic [7:0]                      name_byte;
	logic [tse_pkg::NAME_LEN_W-1:0]  name_len;
	tse_pkg::status_t                status;
	logic                            name_truncated;
	logic                            last_name_byte;

	modport source (output valid, output kind, output name_byte, output name_len,
		output status, output name_truncated, output last_name_byte, input ready);
	modport sink   (input valid, input kind, input name_byte, input name_len,
		input status, input name_truncated, input last_name_byte, output ready);
endinterface

interface tse_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] ext_limit;

	modport source (output valid, output ext_limit, input ready);
	modport sink   (input valid, input ext_limit, output ready);
endinterface

`default_nettype wire

// ----- rtl/tls_sni_extractor.sv -----
// ----------------------------------------------------------------------------
// tls_sni_extractor
// Parses an Ethernet/IPv4/TCP frame byte by byte, finds a TLS ClientHello
// and emits its server-name bytes followed by one end-of-frame verdict.
// ----------------------------------------------------------------------------
// channel  dir  payload                                   handshake
// frame    in   data_byte, frame_end                      valid/ready
// result   out  kind, name_byte, name_len, status,        valid/ready
//               name_truncated, last_name_byte
// cfg      in   ext_limit                                 valid/ready (always ready)
//
// one frame byte per cycle; each byte updates the parse state in the cycle it
// is taken. a byte makes zero, one or two result items (name byte and verdict);
// they queue in a four-entry result buffer, so the result side can stall while
// bytes keep flowing until fewer than two slots are free.
// arst_n clears the parse state, the buffer and sets ext_limit to 20.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_sni_extractor #(
	parameter int NAME_MAX = tse_pkg::NAME_MAX_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	tse_frame_if.sink         frame,
	tse_result_if.source      result,
	tse_cfg_if.sink           cfg
);

	localparam int NR_W     = $clog2(NAME_MAX + 1);
	localparam int FIFO_D   = 4;
	localparam int PTR_W    = $clog2(FIFO_D);
	localparam int CNT_W    = $clog2(FIFO_D + 1);
	localparam logic [15:0] NAME_MAX_L = 16'(NAME_MAX);

	typedef enum logic [3:0] {
		PH_HDR, PH_TCP_REST, PH_REC_HDR, PH_SKIP_FIXED, PH_SID_LEN, PH_SID_SKIP,
		PH_CS_LEN, PH_CS_SKIP, PH_CM_LEN, PH_CM_SKIP, PH_EXT_LEN, PH_EXT_HDR,
		PH_EXT_SKIP, PH_SNI_HDR, PH_NAME, PH_DONE
	} phase_t;

	phase_t            ph_q, ph_d, en_p;
	logic [15:0]       pos_q, pos_d;
	logic [15:0]       nfp_q, nfp_d, en_n;
	logic [15:0]       acc_q, acc_d;
	logic [15:0]       ee_q, ee_d;
	logic [7:0]        ec_q, ec_d;
	logic [NR_W-1:0]   nr_q, nr_d;
	tse_pkg::status_t  vd_q, vd_d, end_st;
	logic [7:0]        ext_limit_q;
	logic              en_req;
	logic [7:0]        b;
	logic [5:0]        hl;

	tse_pkg::result_t  res_a, res_b, name_res, end_res;
	logic [1:0]        n_push;

	tse_pkg::result_t  fifo_q [FIFO_D];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              in_ok, out_ok;

	assign in_ok        = frame.valid && frame.ready;
	assign out_ok       = result.valid && result.ready;
	assign frame.ready  = cnt_q <= CNT_W'(FIFO_D - 2);
	assign cfg.ready    = 1'b1;
	assign b            = frame.data_byte;

	// ------------------------------------------------------------------------
	// parse step for one byte
	// ------------------------------------------------------------------------
	always_comb begin
		ph_d     = ph_q;
		pos_d    = pos_q;
		nfp_d    = nfp_q;
		acc_d    = acc_q;
		ee_d     = ee_q;
		ec_d     = ec_q;
		nr_d     = nr_q;
		vd_d     = vd_q;
		en_req   = 1'b0;
		en_p     = PH_HDR;
		en_n     = '0;
		hl       = '0;
		n_push   = 2'd0;
		name_res = '0;
		end_res  = '0;
		end_st   = tse_pkg::ST_SHORT;

		case (ph_q)
			PH_HDR: begin
				if (pos_q == 16'd23 && b != 8'd6) begin
					vd_d = tse_pkg::ST_NOT_TCP;
					ph_d = PH_DONE;
				end else if (pos_q == 16'd46) begin
					hl = {b[7:4], 2'b00};
					if (hl < 6'd20) begin
						hl = 6'd20;
					end
					en_req = 1'b1;
					en_p   = PH_TCP_REST;
					en_n   = 16'(hl) - 16'd13;
				end
			end
			PH_TCP_REST, PH_SKIP_FIXED, PH_SID_SKIP, PH_CS_SKIP, PH_CM_SKIP,
			PH_EXT_SKIP: begin
				nfp_d = nfp_q - 16'd1;
				if (nfp_d == '0) begin
					en_req = 1'b1;
					en_p   = ph_q;
					en_n   = '0;
				end
			end
			PH_REC_HDR: begin
				nfp_d = nfp_q - 16'd1;
				acc_d = {acc_q[7:0], b};
				if (nfp_q == 16'd6 && b != 8'd22) begin
					vd_d = tse_pkg::ST_NOT_HS;
					ph_d = PH_DONE;
				end else if (nfp_q == 16'd4 && (acc_d < 16'h0301 || acc_d > 16'h0304)) begin
					vd_d = tse_pkg::ST_BAD_VER;
					ph_d = PH_DONE;
				end else if (nfp_q == 16'd1) begin
					if (b != 8'd1) begin
						vd_d = tse_pkg::ST_NOT_HELLO;
						ph_d = PH_DONE;
					end else begin
						// handshake length, client version, random
						en_req = 1'b1;
						en_p   = PH_SKIP_FIXED;
						en_n   = 16'd37;
					end
				end
			end
			PH_SID_LEN: begin
				en_req = 1'b1;
				en_p   = PH_SID_SKIP;
				en_n   = 16'(b);
			end
			PH_CM_LEN: begin
				en_req = 1'b1;
				en_p   = PH_CM_SKIP;
				en_n   = 16'(b);
			end
			PH_CS_LEN, PH_EXT_LEN: begin
				acc_d = {acc_q[7:0], b};
				nfp_d = nfp_q - 16'd1;
				if (nfp_d == '0) begin
					en_req = 1'b1;
					if (ph_q == PH_CS_LEN) begin
						en_p = PH_CS_SKIP;
						en_n = acc_d;
					end else begin
						ee_d = acc_d;
						ec_d = '0;
						en_p = PH_EXT_SKIP;
						en_n = '0;
					end
				end
			end
			PH_EXT_HDR: begin
				nfp_d = nfp_q - 16'd1;
				acc_d = {acc_q[7:0], b};
				if (nfp_q == 16'd3) begin
					if (acc_d == '0) begin
						en_req = 1'b1;
						en_p   = PH_SNI_HDR;
						en_n   = 16'd7;
					end else begin
						acc_d = '0;
					end
				end else if (nfp_q == 16'd1) begin
					ee_d = ee_q - 16'd4;
					if (acc_d > ee_d) begin
						vd_d = tse_pkg::ST_NO_SNI;
						ph_d = PH_DONE;
					end else begin
						ee_d   = ee_d - acc_d;
						en_req = 1'b1;
						en_p   = PH_EXT_SKIP;
						en_n   = acc_d;
					end
				end
			end
			PH_SNI_HDR: begin
				nfp_d = nfp_q - 16'd1;
				// only the two name length bytes are kept
				if (nfp_q <= 16'd2) begin
					acc_d = {acc_q[7:0], b};
				end
				if (nfp_d == '0) begin
					vd_d = tse_pkg::ST_FOUND;
					nr_d = (acc_d > NAME_MAX_L) ? NR_W'(NAME_MAX) : acc_d[NR_W-1:0];
					ph_d = (nr_d == '0) ? PH_DONE : PH_NAME;
				end
			end
			PH_NAME: begin
				nr_d = nr_q - NR_W'(1);
				name_res.kind           = tse_pkg::KIND_NAME;
				name_res.name_byte      = b;
				name_res.name_len       = acc_q;
				name_res.status         = tse_pkg::ST_FOUND;
				name_res.name_truncated = acc_q > NAME_MAX_L;
				name_res.last_name_byte = nr_d == '0;
				n_push = 2'd1;
				if (nr_d == '0) begin
					ph_d = PH_DONE;
				end
			end
			default: begin
			end
		endcase

		// field entry; empty fields fall through to the next one
		if (en_req) begin
			acc_d = '0;
			ph_d  = en_p;
			nfp_d = en_n;
			if (en_n == '0) begin
				case (en_p)
					PH_TCP_REST: begin
						ph_d  = PH_REC_HDR;
						nfp_d = 16'd6;
					end
					PH_SKIP_FIXED: begin
						ph_d  = PH_SID_LEN;
						nfp_d = 16'd1;
					end
					PH_SID_SKIP: begin
						ph_d  = PH_CS_LEN;
						nfp_d = 16'd2;
					end
					PH_CS_SKIP: begin
						ph_d  = PH_CM_LEN;
						nfp_d = 16'd1;
					end
					PH_CM_SKIP: begin
						ph_d  = PH_EXT_LEN;
						nfp_d = 16'd2;
					end
					PH_EXT_SKIP: begin
						if (ec_d >= ext_limit_q || ee_d < 16'd4) begin
							vd_d = tse_pkg::ST_NO_SNI;
							ph_d = PH_DONE;
						end else begin
							ec_d  = ec_d + 8'd1;
							ph_d  = PH_EXT_HDR;
							nfp_d = 16'd4;
						end
					end
					default: begin
					end
				endcase
			end
		end

		if (pos_q != 16'hFFFF) begin
			pos_d = pos_q + 16'd1;
		end

		if (frame.frame_end) begin
			end_st = (ph_d == PH_DONE || ph_d == PH_NAME) ? vd_d : tse_pkg::ST_SHORT;
			end_res.kind   = tse_pkg::KIND_VERDICT;
			end_res.status = end_st;
			if (end_st == tse_pkg::ST_FOUND) begin
				end_res.name_len       = acc_d;
				end_res.name_truncated = acc_d > NAME_MAX_L;
			end
			n_push = n_push + 2'd1;
			ph_d  = PH_HDR;
			pos_d = '0;
			nfp_d = '0;
			acc_d = '0;
			ee_d  = '0;
			ec_d  = '0;
			nr_d  = '0;
			vd_d  = tse_pkg::ST_NO_SNI;
		end
	end

	assign res_a = (ph_q == PH_NAME) ? name_res : end_res;
	assign res_b = end_res;

	// ------------------------------------------------------------------------
	// state registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_HDR;
			pos_q       <= '0;
			nfp_q       <= '0;
			acc_q       <= '0;
			ee_q        <= '0;
			ec_q        <= '0;
			nr_q        <= '0;
			vd_q        <= tse_pkg::ST_NO_SNI;
			ext_limit_q <= tse_pkg::EXT_LIMIT_RST;
		end else begin
			if (in_ok) begin
				ph_q  <= ph_d;
				pos_q <= pos_d;
				nfp_q <= nfp_d;
				acc_q <= acc_d;
				ee_q  <= ee_d;
				ec_q  <= ec_d;
				nr_q  <= nr_d;
				vd_q  <= vd_d;
			end
			if (cfg.valid && cfg.ready) begin
				ext_limit_q <= cfg.ext_limit;
			end
		end
	end

	// ------------------------------------------------------------------------
	// result buffer
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (in_ok) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			end
			if (out_ok) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + (in_ok ? CNT_W'(n_push) : '0) - CNT_W'(out_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (in_ok && n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= res_a;
		end
		if (in_ok && n_push == 2'd2) begin
			fifo_q[wr_ptr_q + PTR_W'(1)] <= res_b;
		end
	end

	assign result.valid          = cnt_q != '0;
	assign result.kind           = fifo_q[rd_ptr_q].kind;
	assign result.name_byte      = fifo_q[rd_ptr_q].name_byte;
	assign result.name_len       = fifo_q[rd_ptr_q].name_len;
	assign result.status         = fifo_q[rd_ptr_q].status;
	assign result.name_truncated = fifo_q[rd_ptr_q].name_truncated;
	assign result.last_name_byte = fifo_q[rd_ptr_q].last_name_byte;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_D))
		else $error("result buffer overfilled");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_ok && frame.frame_end |=> ph_q == PH_HDR && pos_q == '0)
		else $error("parse state not cleared after frame end");

	a_name_found: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_NAME |-> vd_q == tse_pkg::ST_FOUND && nr_q != '0)
		else $error("name phase without a found verdict");

	a_verdict_len: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.kind == tse_pkg::KIND_VERDICT &&
		result.status != tse_pkg::ST_FOUND |-> result.name_len == '0 && !result.name_truncated)
		else $error("failed verdict carries a name length");

endmodule

`default_nettype wire

// ----- test/tls_sni_extractor_tb.sv -----
// ----------------------------------------------------------------------------
// tls_sni_extractor_tb
// Sends whole Ethernet frames byte by byte, a directed table of frames first
// and then random ClientHello frames with corrupted ones mixed in; checks each
// name byte and end-of-frame verdict against a bench model (typed rows: table).
// ----------------------------------------------------------------------------
`default_nettype none

module tls_sni_extractor_tb;

	localparam int NAME_MAX    = tse_pkg::NAME_MAX_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int RAND_BYTES  = 150;

	typedef enum logic [3:0] {
		P_ETH_IP, P_TCP_OPT, P_RECORD, P_HELLO_FIXED, P_SID_LEN, P_SID, P_CS_LEN, P_CS,
		P_CM_LEN, P_CM, P_EXT_LEN, P_EXT_HDR, P_EXT_BODY, P_SNI_HDR, P_NAME, P_DONE
	} parse_phase_t;

	// one frame recipe; cut > 0 keeps that many bytes, cut < 0 drops bytes at the end
	typedef struct packed {
		int               proto;
		int               doff;
		int               ctype;
		int               ver;
		int               hstype;
		int               sid_len;
		int               cs_len;
		int               cm_len;
		int               n_pad;
		int               pad_len;
		int               sni;
		int               name_len;
		int               ext_adj;
		int               tail;
		int               cut;
		logic             typed;
		tse_pkg::status_t want;
	} frame_spec_t;

	typedef struct packed {
		logic             on;
		tse_pkg::status_t st;
	} pinned_verdict_t;

	logic clk;
	logic arst_n;

	tse_frame_if  frame_if();
	tse_result_if result_if();
	tse_cfg_if    cfg_if();

	tls_sni_extractor #(.NAME_MAX(NAME_MAX)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	// parse model state
	logic [15:0]      pos_q;
	parse_phase_t     phase_q;
	logic [15:0]      left_q;
	logic [15:0]      acc_q;
	logic [15:0]      ext_rem_q;
	logic [7:0]       ext_cnt_q;
	logic [15:0]      name_rem_q;
	tse_pkg::status_t verdict_q;
	logic [7:0]       lim_q;

	tse_pkg::result_t sni_due_q[$];
	pinned_verdict_t  pin_q[$];
	logic [7:0]       frm_q[$];
	frame_spec_t      dir_tab[14];

	int               n_err;
	int               stall;
	int               src_idle;
	int               snk_idle;
	int               cur_limit;
	logic             moved;
	pinned_verdict_t  pin_now;
	tse_pkg::result_t pinned;
	tse_pkg::result_t got;

	always #2 clk = ~clk;

	always @(posedge clk)
		result_if.ready <= ($urandom_range(0, 99) >= snk_idle);

	function automatic void clear_frame();
		pos_q      = '0;
		phase_q    = P_ETH_IP;
		left_q     = '0;
		acc_q      = '0;
		ext_rem_q  = '0;
		ext_cnt_q  = '0;
		name_rem_q = '0;
		verdict_q  = tse_pkg::ST_NO_SNI;
	endfunction

	function automatic void conclude(tse_pkg::status_t v);
		verdict_q = v;
		phase_q   = P_DONE;
	endfunction

	// enter a field; empty skip fields fall through to the next one
	function automatic void advance(parse_phase_t p_in, logic [15:0] n_in);
		parse_phase_t p;
		logic [15:0]  n;
		bit           go;
		p     = p_in;
		n     = n_in;
		acc_q = '0;
		go    = 1'b1;
		while (go) begin
			phase_q = p;
			left_q  = n;
			if (n != 0) begin
				go = 1'b0;
			end else begin
				case (p)
					P_TCP_OPT: begin
						p = P_RECORD;
						n = 6;
					end
					P_HELLO_FIXED: begin
						p = P_SID_LEN;
						n = 1;
					end
					P_SID: begin
						p = P_CS_LEN;
						n = 2;
					end
					P_CS: begin
						p = P_CM_LEN;
						n = 1;
					end
					P_CM: begin
						p = P_EXT_LEN;
						n = 2;
					end
					P_EXT_BODY: begin
						if (ext_cnt_q >= lim_q || ext_rem_q < 4) begin
							conclude(tse_pkg::ST_NO_SNI);
							go = 1'b0;
						end else begin
							ext_cnt_q++;
							p = P_EXT_HDR;
							n = 4;
						end
					end
					default: go = 1'b0;
				endcase
			end
		end
	endfunction

	function automatic void parse_byte(logic [7:0] b, logic fin);
		int               k;
		int               hl;
		logic [15:0]      len;
		tse_pkg::result_t r;
		case (phase_q)
			P_ETH_IP: begin
				if (pos_q == 23 && b != 8'd6) begin
					conclude(tse_pkg::ST_NOT_TCP);
				end else if (pos_q == 46) begin
					hl = (b >> 4) * 4;
					if (hl < 20)
						hl = 20;
					advance(P_TCP_OPT, 16'(hl - 13));
				end
			end
			P_TCP_OPT, P_HELLO_FIXED, P_SID, P_CS, P_CM, P_EXT_BODY: begin
				left_q--;
				if (left_q == 0)
					advance(phase_q, 16'd0);
			end
			P_RECORD: begin
				k = 6 - left_q;
				left_q--;
				acc_q = {acc_q[7:0], b};
				if (k == 0 && b != 8'd22) begin
					conclude(tse_pkg::ST_NOT_HS);
				end else if (k == 2 && (acc_q < 16'h0301 || acc_q > 16'h0304)) begin
					conclude(tse_pkg::ST_BAD_VER);
				end else if (k == 5) begin
					if (b != 8'd1)
						conclude(tse_pkg::ST_NOT_HELLO);
					else
						advance(P_HELLO_FIXED, 16'd37);
				end
			end
			P_SID_LEN: advance(P_SID, {8'd0, b});
			P_CM_LEN:  advance(P_CM, {8'd0, b});
			P_CS_LEN, P_EXT_LEN: begin
				acc_q = {acc_q[7:0], b};
				left_q--;
				if (left_q == 0) begin
					if (phase_q == P_CS_LEN) begin
						advance(P_CS, acc_q);
					end else begin
						ext_rem_q = acc_q;
						ext_cnt_q = '0;
						advance(P_EXT_BODY, 16'd0);
					end
				end
			end
			P_EXT_HDR: begin
				k = 4 - left_q;
				left_q--;
				acc_q = {acc_q[7:0], b};
				if (k == 1) begin
					if (acc_q == 0)
						advance(P_SNI_HDR, 16'd7);
					else
						acc_q = '0;
				end else if (k == 3) begin
					len       = acc_q;
					ext_rem_q = ext_rem_q - 16'd4;
					if (len > ext_rem_q) begin
						conclude(tse_pkg::ST_NO_SNI);
					end else begin
						ext_rem_q = ext_rem_q - len;
						advance(P_EXT_BODY, len);
					end
				end
			end
			P_SNI_HDR: begin
				k = 7 - left_q;
				left_q--;
				if (k >= 5)
					acc_q = {acc_q[7:0], b};
				if (left_q == 0) begin
					verdict_q  = tse_pkg::ST_FOUND;
					name_rem_q = (acc_q > NAME_MAX) ? 16'(NAME_MAX) : acc_q;
					phase_q    = (name_rem_q == 0) ? P_DONE : P_NAME;
				end
			end
			P_NAME: begin
				name_rem_q--;
				r.kind           = tse_pkg::KIND_NAME;
				r.name_byte      = b;
				r.name_len       = acc_q;
				r.status         = tse_pkg::ST_FOUND;
				r.name_truncated = (acc_q > NAME_MAX);
				r.last_name_byte = (name_rem_q == 0);
				sni_due_q.push_back(r);
				if (name_rem_q == 0)
					phase_q = P_DONE;
			end
			default: ;
		endcase
		if (pos_q != 16'hFFFF)
			pos_q++;
		if (fin) begin
			r = '0;
			r.kind   = tse_pkg::KIND_VERDICT;
			r.status = (phase_q == P_DONE || phase_q == P_NAME) ? verdict_q
				: tse_pkg::ST_SHORT;
			if (r.status == tse_pkg::ST_FOUND) begin
				r.name_len       = acc_q;
				r.name_truncated = (acc_q > NAME_MAX);
			end
			sni_due_q.push_back(r);
			clear_frame();
		end
	endfunction

	function automatic void flag(string what, logic [15:0] want, logic [15:0] act);
		$display("%0t mismatch %s: expected %0h actual %0h", $time, what, want, act);
		n_err++;
	endfunction

	function automatic void check_result(tse_pkg::result_t want, tse_pkg::result_t act);
		if (act.kind !== want.kind)
			flag("kind", want.kind, act.kind);
		if (act.name_byte !== want.name_byte)
			flag("name_byte", want.name_byte, act.name_byte);
		if (act.name_len !== want.name_len)
			flag("name_len", want.name_len, act.name_len);
		if (act.status !== want.status)
			flag("status", want.status, act.status);
		if (act.name_truncated !== want.name_truncated)
			flag("name_truncated", want.name_truncated, act.name_truncated);
		if (act.last_name_byte !== want.last_name_byte)
			flag("last_name_byte", want.last_name_byte, act.last_name_byte);
	endfunction

	// all handshakes are seen here, in one process, with pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_if.valid && cfg_if.ready) begin
				lim_q = cfg_if.ext_limit;
				moved = 1'b1;
			end
			if (frame_if.valid && frame_if.ready) begin
				parse_byte(frame_if.data_byte, frame_if.frame_end);
				if (frame_if.frame_end) begin
					pin_now = pin_q.pop_front();
					if (pin_now.on) begin
						void'(sni_due_q.pop_back());
						pinned        = '0;
						pinned.kind   = tse_pkg::KIND_VERDICT;
						pinned.status = pin_now.st;
						sni_due_q.push_back(pinned);
					end
				end
				moved = 1'b1;
			end
			if (result_if.valid && result_if.ready) begin
				got.kind           = result_if.kind;
				got.name_byte      = result_if.name_byte;
				got.name_len       = result_if.name_len;
				got.status         = result_if.status;
				got.name_truncated = result_if.name_truncated;
				got.last_name_byte = result_if.last_name_byte;
				if (sni_due_q.size() == 0) begin
					$display("%0t unexpected item: expected none actual %p", $time, got);
					n_err++;
				end else begin
					check_result(sni_due_q.pop_front(), got);
				end
				moved = 1'b1;
			end
			stall = moved ? 0 : stall + 1;
			if (stall >= STALL_LIMIT) begin
				$display("%0t watchdog: nothing moved for %0d cycles", $time, stall);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	function automatic void add_random(int n);
		repeat (n)
			frm_q.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void push16(int v);
		frm_q.push_back(8'(v >> 8));
		frm_q.push_back(8'(v));
	endfunction

	function automatic void build_frame(frame_spec_t s);
		int          hl;
		int          ext_field;
		int          drop;
		logic [15:0] pad_type;
		frm_q.delete();
		add_random(23);
		frm_q.push_back(8'(s.proto));
		add_random(22);
		frm_q.push_back(8'((s.doff << 4) | $urandom_range(0, 15)));
		hl = (s.doff * 4 < 20) ? 20 : s.doff * 4;
		add_random(hl - 13);
		frm_q.push_back(8'(s.ctype));
		push16(s.ver);
		add_random(2);
		frm_q.push_back(8'(s.hstype));
		add_random(37);
		frm_q.push_back(8'(s.sid_len));
		add_random(s.sid_len);
		push16(s.cs_len);
		add_random(s.cs_len);
		frm_q.push_back(8'(s.cm_len));
		add_random(s.cm_len);
		ext_field = s.n_pad * (4 + s.pad_len) + (s.sni != 0 ? 9 + s.name_len : 0) + s.ext_adj;
		push16(ext_field < 0 ? 0 : ext_field);
		repeat (s.n_pad) begin
			// nonzero type, sometimes with a zero high byte
			if ($urandom_range(0, 3) == 0)
				pad_type = 16'($urandom_range(1, 255));
			else
				pad_type = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
			push16(pad_type);
			push16(s.pad_len);
			add_random(s.pad_len);
		end
		if (s.sni != 0) begin
			push16(0);
			push16(s.name_len + 5);
			push16(s.name_len + 3);
			frm_q.push_back(8'd0);
			push16(s.name_len);
			add_random(s.name_len);
		end
		add_random(s.tail);
		if (s.cut > 0) begin
			while (frm_q.size() > s.cut)
				void'(frm_q.pop_back());
		end else if (s.cut < 0) begin
			drop = -s.cut;
			if (drop > frm_q.size() - 1)
				drop = frm_q.size() - 1;
			repeat (drop)
				void'(frm_q.pop_back());
		end
	endfunction

	function automatic frame_spec_t rand_spec();
		frame_spec_t s;
		int          r;
		s.proto    = 6;
		s.doff     = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 15)) : 5;
		s.ctype    = 22;
		s.ver      = 'h0301 + int'($urandom_range(0, 3));
		s.hstype   = 1;
		s.sid_len  = ($urandom_range(0, 3) == 0) ? 32 : int'($urandom_range(0, 6));
		s.cs_len   = 2 * int'($urandom_range(0, 6));
		s.cm_len   = $urandom_range(0, 2);
		s.n_pad    = $urandom_range(0, (cur_limit < 4) ? cur_limit : 4);
		s.pad_len  = $urandom_range(0, 8);
		s.sni      = ($urandom_range(0, 9) != 0);
		r          = $urandom_range(0, 19);
		s.name_len = (r == 0) ? int'($urandom_range(257, 280)) :
			(r == 1) ? NAME_MAX : int'($urandom_range(0, 24));
		s.ext_adj  = 0;
		s.tail     = $urandom_range(0, 4);
		s.cut      = 0;
		s.typed    = 1'b0;
		s.want     = tse_pkg::ST_FOUND;
		// a share of the frames is broken in one place
		if ($urandom_range(0, 99) < 30) begin
			case ($urandom_range(0, 8))
				0: s.proto  = $urandom_range(0, 255);
				1: s.ctype  = $urandom_range(0, 255);
				2: s.ver    = ($urandom_range(0, 1) == 0) ? 'h0300 : 'h0305;
				3: s.hstype = $urandom_range(0, 255);
				4: s.ext_adj = int'($urandom_range(0, 12)) - 6;
				5: s.cut    = $urandom_range(1, 140);
				6: s.cut    = -int'($urandom_range(1, 30));
				7: begin
					s.sid_len = $urandom_range(0, 255);
					s.cs_len  = $urandom_range(0, 300);
					s.cm_len  = $urandom_range(0, 255);
				end
				default: begin
					if (cur_limit <= 6) begin
						s.n_pad   = cur_limit + int'($urandom_range(0, 1));
						s.pad_len = $urandom_range(0, 3);
					end else begin
						s.n_pad = 0;
						s.sni   = 0;
					end
				end
			endcase
		end
		return s;
	endfunction

	task automatic send_frame(frame_spec_t s);
		pinned_verdict_t pv;
		build_frame(s);
		pv.on = s.typed;
		pv.st = s.want;
		pin_q.push_back(pv);
		for (int i = 0; i < frm_q.size(); i++) begin
			while ($urandom_range(0, 99) < src_idle) begin
				frame_if.valid <= 1'b0;
				@(posedge clk);
			end
			frame_if.valid     <= 1'b1;
			frame_if.data_byte <= frm_q[i];
			frame_if.frame_end <= (i == frm_q.size() - 1);
			@(posedge clk);
			while (!frame_if.ready)
				@(posedge clk);
		end
	endtask

	task automatic run_random(int budget);
		int sent;
		sent = 0;
		while (sent < budget) begin
			send_frame(rand_spec());
			sent += frm_q.size();
		end
	endtask

	// stop sending and let every due item drain
	task automatic settle();
		frame_if.valid <= 1'b0;
		@(posedge clk);
		while (sni_due_q.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic set_limit(logic [7:0] v);
		cfg_if.valid     <= 1'b1;
		cfg_if.ext_limit <= v;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		cur_limit = v;
	endtask

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		frame_if.valid     = 1'b0;
		frame_if.data_byte = '0;
		frame_if.frame_end = 1'b0;
		cfg_if.valid       = 1'b0;
		cfg_if.ext_limit   = '0;
		n_err              = 0;
		stall              = 0;
		lim_q              = tse_pkg::EXT_LIMIT_RST;
		cur_limit          = int'(tse_pkg::EXT_LIMIT_RST);
		clear_frame();
		src_idle = 21;
		snk_idle = 69;

		// proto doff ctype ver hstype sid cs cm pads padlen sni name adj tail cut typed want
		dir_tab = '{
			'{6, 5, 22, 'h0303, 1, 0, 2, 1, 0, 0, 1, 4, 0, 0, 1, 1'b1, tse_pkg::ST_SHORT},
			'{17, 5, 22, 'h0303, 1, 0, 2, 1, 0, 0, 1, 4, 0, 0, 24, 1'b1, tse_pkg::ST_NOT_TCP},
			'{6, 5, 23, 'h0303, 1, 0, 2, 1, 0, 0, 1, 4, 0, 0, 55, 1'b1, tse_pkg::ST_NOT_HS},
			'{6, 5, 22, 'h0300, 1, 0, 2, 1, 0, 0, 1, 4, 0, 0, 57, 1'b1, tse_pkg::ST_BAD_VER},
			'{6, 5, 22, 'h0305, 1, 0, 2, 1, 0, 0, 1, 4, 0, 0, 57, 1'b1, tse_pkg::ST_BAD_VER},
			'{6, 5, 22, 'h0302, 2, 0, 2, 1, 0, 0, 1, 4, 0, 0, 60, 1'b1, tse_pkg::ST_NOT_HELLO},
			'{6, 5, 22, 'h0302, 0, 0, 2, 1, 0, 0, 1, 4, 0, 0, 60, 1'b1, tse_pkg::ST_NOT_HELLO},
			'{6, 15, 22, 'h0303, 1, 0, 2, 1, 0, 0, 0, 0, 0, 0, 0, 1'b1, tse_pkg::ST_NO_SNI},
			'{6, 5, 22, 'h0303, 1, 0, 2, 1, 2, 3, 0, 0, 2, 0, 0, 1'b1, tse_pkg::ST_NO_SNI},
			'{6, 5, 22, 'h0303, 1, 32, 2, 1, 1, 10, 0, 0, -1, 0, 0, 1'b1, tse_pkg::ST_NO_SNI},
			'{6, 5, 22, 'h0303, 1, 0, 2, 1, 20, 0, 1, 4, 0, 0, 0, 1'b1, tse_pkg::ST_NO_SNI},
			'{6, 0, 22, 'h0301, 1, 0, 2, 1, 0, 0, 1, 0, 0, 2, 0, 1'b1, tse_pkg::ST_FOUND},
			'{6, 5, 22, 'h0303, 1, 0, 2, 1, 0, 0, 1, 257, 0, 1, 0, 1'b0, tse_pkg::ST_FOUND},
			'{6, 5, 22, 'h0304, 1, 0, 2, 1, 0, 0, 1, 256, 0, 0, 123, 1'b0, tse_pkg::ST_FOUND}
		};

		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[row])
			send_frame(dir_tab[row]);
		settle();

		set_limit(8'd1);
		run_random(RAND_BYTES / 3);
		settle();

		src_idle = 69;
		snk_idle = 21;
		set_limit(8'd255);
		run_random(RAND_BYTES / 3);
		settle();

		src_idle = 0;
		snk_idle = 0;
		set_limit(8'($urandom_range(2, 6)));
		run_random(RAND_BYTES / 3);
		settle();

		if (n_err == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
